@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks on clk; all but the ALWAYS form are off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define LCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset.
`define LCD_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants of the line crossing detector.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int ID_W       = 8;
  localparam int TAG_W      = 16;
  localparam int CFG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_Y   = 3'd3;

  // register reset values
  localparam int START_X_RST = 500;
  localparam int START_Y_RST = 0;
  localparam int END_X_RST   = 500;
  localparam int END_Y_RST   = 700;

  typedef enum logic {
    SIDE_TWO = 1'b0,
    SIDE_ONE = 1'b1
  } side_t;

  typedef struct packed {
    logic  seen;
    side_t side;
  } entry_t;

endpackage

@@ sv/lcd_cross.sv @@
// ----------------------------------------------------------------------------
// lcd_cross
// Side of a point relative to the configured line: registered cross product
// terms, sign taken on the register outputs.
// ----------------------------------------------------------------------------
module lcd_cross #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  output lcd_pkg::side_t        side
);
  import lcd_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [DW-1:0] line_dx, line_dy, pt_dx, pt_dy;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [CW-1:0] cross_val;

  assign line_dx = $signed({1'b0, end_x})   - $signed({1'b0, start_x});
  assign line_dy = $signed({1'b0, end_y})   - $signed({1'b0, start_y});
  assign pt_dx   = $signed({1'b0, point_x}) - $signed({1'b0, start_x});
  assign pt_dy   = $signed({1'b0, point_y}) - $signed({1'b0, start_y});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= line_dx * pt_dy;
      prod_b <= pt_dx * line_dy;
    end
  end

  assign cross_val = CW'(prod_a) - CW'(prod_b);

  // strictly positive is side one; on the line counts as side two
  assign side = (!cross_val[CW-1] && (cross_val != '0)) ? SIDE_ONE : SIDE_TWO;

endmodule

@@ sv/line_crossing_detector_top.sv @@
// ----------------------------------------------------------------------------
// line_crossing_detector_top: one observation per cycle while in_stall is low.
// Two stages: table read plus cross product multiply, then sign and write-back.
// Sync reset clears control, then a clear of all MAX_BLOBS table slots holds off input.
// ----------------------------------------------------------------------------
module line_crossing_detector_top #(
  parameter int MAX_BLOBS  = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lcd_pkg::ID_W-1:0]        blob_id,
  input  logic [lcd_pkg::TAG_W-1:0]       event_tag,
  input  logic [COORD_BITS-1:0]           centroid_x,
  input  logic [COORD_BITS-1:0]           centroid_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lcd_pkg::ID_W-1:0]        crossed_id,
  output logic [lcd_pkg::TAG_W-1:0]       crossed_tag,
  output logic                            direction
);
  import lcd_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_BLOBS);
  localparam int ID_SPAN = 1 << ID_W;

  // line configuration
  logic [COORD_BITS-1:0] line_start_x, line_start_y, line_end_x, line_end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_start_x <= COORD_BITS'(START_X_RST);
      line_start_y <= COORD_BITS'(START_Y_RST);
      line_end_x   <= COORD_BITS'(END_X_RST);
      line_end_y   <= COORD_BITS'(END_Y_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: line_start_x <= cfg_data;
        REG_START_Y: line_start_y <= cfg_data;
        REG_END_X:   line_end_x   <= cfg_data;
        REG_END_Y:   line_end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // id to table slot, wraps on the table depth
  logic [SLOT_W-1:0] slot_lut [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % MAX_BLOBS);
  end

  logic [SLOT_W-1:0] in_slot;
  assign in_slot = slot_lut[blob_id];

  // clearing pass after reset
  logic              clr_active;
  logic [SLOT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == SLOT_W'(MAX_BLOBS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // pipeline control
  logic advance, accept;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = clr_active || !advance;
  assign accept   = in_valid && !in_stall;

  // stage 1 request
  logic               s1_valid;
  logic [ID_W-1:0]    s1_id;
  logic [TAG_W-1:0]   s1_tag;
  logic [SLOT_W-1:0]  s1_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
    if (advance) begin
      s1_id   <= blob_id;
      s1_tag  <= event_tag;
      s1_slot <= in_slot;
    end
  end

  side_t cur_side;

  lcd_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk    (clk),
    .en     (advance),
    .start_x(line_start_x),
    .start_y(line_start_y),
    .end_x  (line_end_x),
    .end_y  (line_end_y),
    .point_x(centroid_x),
    .point_y(centroid_y),
    .side   (cur_side)
  );

  // side table
  entry_t            mem [MAX_BLOBS];
  entry_t            rd_data;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  assign mem_we    = clr_active || (advance && s1_valid);
  assign mem_waddr = clr_active ? clr_addr : s1_slot;
  assign mem_wdata = clr_active ? entry_t'('0) : entry_t'{seen: 1'b1, side: cur_side};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (advance) begin
      rd_data <= mem[in_slot];
    end
  end

  // last write bypass: the read of the next request overlaps this write
  logic              fwd_valid;
  logic [SLOT_W-1:0] fwd_slot;
  entry_t            fwd_data;

  always_ff @(posedge clk) begin
    if (rst || clr_active) begin
      fwd_valid <= 1'b0;
    end else if (advance && s1_valid) begin
      fwd_valid <= 1'b1;
    end
    if (advance && s1_valid) begin
      fwd_slot <= s1_slot;
      fwd_data <= mem_wdata;
    end
  end

  entry_t prev;
  logic   crossing;
  assign prev     = (fwd_valid && (fwd_slot == s1_slot)) ? fwd_data : rd_data;
  assign crossing = prev.seen && (prev.side != cur_side);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && crossing;
    end
    if (advance) begin
      crossed_id  <= s1_id;
      crossed_tag <= s1_tag;
      direction   <= (cur_side == SIDE_TWO);
    end
  end

endmodule

@@ sv/lcd_checker.sv @@
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks of the line crossing detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [lcd_pkg::ID_W-1:0]  crossed_id,
  input logic [lcd_pkg::TAG_W-1:0] crossed_tag,
  input logic                     direction
);

  // reset empties the output and starts the table clear
  `LCD_ASSERT_NEXT_ALWAYS(a_rst_out, rst, !out_valid, "output valid after reset")
  `LCD_ASSERT_NEXT_ALWAYS(a_rst_clr, rst, in_stall, "input open during table clear")

  // a held result blocks new requests
  `LCD_ASSERT_SAME(a_bp, out_valid && out_stall, in_stall, "input taken while output held")

  // a fresh result follows a request accepted through the stage 1 and output registers
  `LCD_ASSERT_SAME(a_src, $rose(out_valid),
    $past(in_valid && !in_stall, 2), "result without request")

  `LCD_ASSERT_NEXT(a_hold, out_valid && out_stall,
    out_valid && $stable(crossed_id) && $stable(crossed_tag) && $stable(direction),
    "stalled result changed")

endmodule

bind line_crossing_detector_top lcd_checker u_lcd_checker (.*);
